// ===== design/kcc_pkg.sv =====
`timescale 1ns / 1ps

package kcc_pkg;

  localparam int KMER_LEN_DEF   = 8;
  localparam int COUNT_BITS_DEF = 24;
  localparam int TABLE_AW       = 16;
  localparam int TABLE_DEPTH    = 1 << TABLE_AW;
  localparam int OUT_COUNT_W    = 24;
  localparam int MODE_W         = 2;
  localparam int CODE_W         = 3;

  localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = '1;

  localparam logic [7:0] CH_A_UC = 8'h41;
  localparam logic [7:0] CH_C_UC = 8'h43;
  localparam logic [7:0] CH_G_UC = 8'h47;
  localparam logic [7:0] CH_T_UC = 8'h54;
  localparam logic [7:0] CH_A_LC = 8'h61;
  localparam logic [7:0] CH_C_LC = 8'h63;
  localparam logic [7:0] CH_G_LC = 8'h67;
  localparam logic [7:0] CH_T_LC = 8'h74;

  localparam logic [CODE_W-1:0] CODE_A   = 3'd0;
  localparam logic [CODE_W-1:0] CODE_C   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_G   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_T   = 3'd3;
  localparam logic [CODE_W-1:0] CODE_BAD = 3'd4;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_END  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CANON = 2'd0,
    MODE_FWD   = 2'd1,
    MODE_REV   = 2'd2
  } mode_t;

  typedef enum logic {
    PH_CLEAR,
    PH_RUN
  } phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  base_char;
    logic [15:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0]            kmer_index;
    logic [OUT_COUNT_W-1:0] kmer_count;
  } out_item_t;

  // Request from the k-mer front end to the counter update stage.
  typedef struct packed {
    logic                inc;
    logic                rd;
    logic [TABLE_AW-1:0] addr;
  } req_t;

  function automatic logic [CODE_W-1:0] base_code(input logic [7:0] ch);
    logic [CODE_W-1:0] code;
    unique case (ch)
      CH_A_UC, CH_A_LC: code = CODE_A;
      CH_C_UC, CH_C_LC: code = CODE_C;
      CH_G_UC, CH_G_LC: code = CODE_G;
      CH_T_UC, CH_T_LC: code = CODE_T;
      default:          code = CODE_BAD;
    endcase
    return code;
  endfunction

endpackage

// ===== design/canonical_kmer_counter_top.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                  Handshake
// input     start, busy, in_data                   taken when start && !busy
// result    out_valid, out_data                    one-cycle strobe, no backpressure
// config    cfg_valid, cfg_ready, cfg_data         taken when cfg_valid && cfg_ready
//
// After reset the count memory is swept to zero, one entry per cycle, with busy
// held high. Afterwards one beat is taken every cycle; the count update is a
// read-modify-write on the single count memory, with the previous beat's write
// forwarded. A read beat's result is registered in the s1 stage and then in the
// output register. The result side cannot stall; cfg_ready is always high.

module canonical_kmer_counter_top #(
  parameter int KMER_LEN   = kcc_pkg::KMER_LEN_DEF,
  parameter int COUNT_BITS = kcc_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  kcc_pkg::in_item_t          in_data,
  output logic                       out_valid,
  output kcc_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kcc_pkg::MODE_W-1:0] cfg_data
);

  logic [kcc_pkg::MODE_W-1:0]   strand_mode_r;
  logic                         accept;
  kcc_pkg::req_t                req;
  logic                         ram_re, ram_we;
  logic [kcc_pkg::TABLE_AW-1:0] ram_raddr, ram_waddr;
  logic [COUNT_BITS-1:0]        ram_rdata, ram_wdata;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strand_mode_r <= kcc_pkg::MODE_CANON;
    end else if (cfg_valid && cfg_ready) begin
      strand_mode_r <= cfg_data;
    end
  end

  kcc_kmer #(
    .KMER_LEN (KMER_LEN)
  ) u_kmer (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_data),
    .strand_mode (strand_mode_r),
    .req         (req)
  );

  kcc_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .ram_rdata (ram_rdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

  kcc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (kcc_pkg::TABLE_DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== design/kcc_ram.sv =====
`timescale 1ns / 1ps

module kcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/kcc_kmer.sv =====
`timescale 1ns / 1ps

module kcc_kmer #(
  parameter int KMER_LEN = kcc_pkg::KMER_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  kcc_pkg::in_item_t           item,
  input  logic [kcc_pkg::MODE_W-1:0]  strand_mode,
  output kcc_pkg::req_t               req
);

  localparam int KW   = 2 * KMER_LEN;
  localparam int LB_W = (KMER_LEN > 1) ? $clog2(KMER_LEN) : 1;

  logic [KW-1:0]   fwd_r, fwd_nxt;
  logic [KW-1:0]   rev_r, rev_nxt;
  logic [LB_W-1:0] loaded_r, loaded_nxt;

  logic [kcc_pkg::CODE_W-1:0]        code;
  logic                              valid_base;
  logic [1:0]                        c2;
  logic [KW-1:0]                     fwd_sh, rev_sh, pick;
  logic [KW+kcc_pkg::TABLE_AW-1:0]   pick_ext;
  logic                              full;

  always_comb begin
    code       = kcc_pkg::base_code(item.base_char);
    valid_base = (code != kcc_pkg::CODE_BAD);
    c2         = code[1:0];
    fwd_sh     = (fwd_r << 2) | KW'(c2);
    // The complement of a 2-bit code is its bitwise inverse.
    rev_sh     = (rev_r >> 2) | (KW'(~c2) << (KW - 2));
    full       = !(loaded_r < LB_W'(KMER_LEN - 1));
    unique case (strand_mode)
      kcc_pkg::MODE_CANON: pick = (fwd_sh < rev_sh) ? fwd_sh : rev_sh;
      kcc_pkg::MODE_FWD:   pick = fwd_sh;
      default:             pick = rev_sh;
    endcase
    pick_ext = {{kcc_pkg::TABLE_AW{1'b0}}, pick};
  end

  always_comb begin
    fwd_nxt    = fwd_r;
    rev_nxt    = rev_r;
    loaded_nxt = loaded_r;
    req.inc    = 1'b0;
    req.rd     = 1'b0;
    req.addr   = pick_ext[kcc_pkg::TABLE_AW-1:0];
    if (accept) begin
      unique case (item.command)
        kcc_pkg::CMD_ADD: begin
          if (valid_base) begin
            fwd_nxt = fwd_sh;
            rev_nxt = rev_sh;
            if (full) begin
              req.inc = 1'b1;
            end else begin
              loaded_nxt = loaded_r + LB_W'(1);
            end
          end else begin
            loaded_nxt = '0;
          end
        end
        kcc_pkg::CMD_END: begin
          loaded_nxt = '0;
        end
        kcc_pkg::CMD_READ: begin
          req.rd   = 1'b1;
          req.addr = item.read_index;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r    <= '0;
      rev_r    <= '0;
      loaded_r <= '0;
    end else begin
      fwd_r    <= fwd_nxt;
      rev_r    <= rev_nxt;
      loaded_r <= loaded_nxt;
    end
  end

endmodule

// ===== design/kcc_update.sv =====
`timescale 1ns / 1ps

module kcc_update #(
  parameter int COUNT_BITS = kcc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kcc_pkg::req_t                 req,
  input  logic [COUNT_BITS-1:0]         ram_rdata,
  output logic                          ram_re,
  output logic [kcc_pkg::TABLE_AW-1:0]  ram_raddr,
  output logic                          ram_we,
  output logic [kcc_pkg::TABLE_AW-1:0]  ram_waddr,
  output logic [COUNT_BITS-1:0]         ram_wdata,
  output logic                          busy,
  output logic                          out_valid,
  output kcc_pkg::out_item_t            out_item
);

  localparam int AW = kcc_pkg::TABLE_AW;
  localparam int OW = kcc_pkg::OUT_COUNT_W;

  kcc_pkg::phase_t phase_r, phase_nxt;
  logic [AW-1:0]   clr_addr_r;

  logic            s1_inc_r, s1_rd_r;
  logic [AW-1:0]   s1_addr_r;

  logic                  fwd_valid_r;
  logic [AW-1:0]         fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic                  out_valid_r;
  kcc_pkg::out_item_t    out_item_r;

  logic [COUNT_BITS-1:0]    cur, inc_val;
  logic [COUNT_BITS+OW-1:0] cur_ext;
  logic [OW-1:0]            cur_clamp;

  assign ram_re    = req.inc | req.rd;
  assign ram_raddr = req.addr;

  // The write of the previous beat lands at the same edge as this beat's read,
  // so the memory returns stale data for that one address.
  always_comb begin
    cur       = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : ram_rdata;
    inc_val   = (cur == '1) ? cur : cur + COUNT_BITS'(1);
    cur_ext   = {{OW{1'b0}}, cur};
    cur_clamp = (cur_ext > {{COUNT_BITS{1'b0}}, kcc_pkg::OUT_COUNT_MAX}) ?
                kcc_pkg::OUT_COUNT_MAX : cur_ext[OW-1:0];
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      kcc_pkg::PH_CLEAR: begin
        if (clr_addr_r == '1) begin
          phase_nxt = kcc_pkg::PH_RUN;
        end
      end
      kcc_pkg::PH_RUN: phase_nxt = kcc_pkg::PH_RUN;
      default:         phase_nxt = kcc_pkg::PH_CLEAR;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    unique case (phase_r)
      kcc_pkg::PH_CLEAR: begin
        busy   = 1'b1;
        ram_we = 1'b1;
      end
      kcc_pkg::PH_RUN: begin
        busy      = 1'b0;
        ram_we    = s1_inc_r;
        ram_waddr = s1_addr_r;
        ram_wdata = inc_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= kcc_pkg::PH_CLEAR;
      clr_addr_r  <= '0;
      s1_inc_r    <= 1'b0;
      s1_rd_r     <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      if (phase_r == kcc_pkg::PH_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      s1_inc_r    <= req.inc;
      s1_rd_r     <= req.rd;
      fwd_valid_r <= s1_inc_r;
      out_valid_r <= s1_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r             <= req.addr;
    fwd_addr_r            <= s1_addr_r;
    fwd_data_r            <= inc_val;
    out_item_r.kmer_index <= s1_addr_r;
    out_item_r.kmer_count <= cur_clamp;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== design/kcc_checker.sv =====
`timescale 1ns / 1ps

module kcc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input kcc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input kcc_pkg::out_item_t out_data
);

  // Reset always starts the clearing sweep.
  a_reset_clears : assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // Once the sweep is over, only a reset can raise busy again.
  a_busy_rise : assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("busy rose without reset");

  a_read_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.command == kcc_pkg::CMD_READ) |-> ##2 out_valid)
    else $error("read beat produced no result");

  a_result_origin : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_data.command == kcc_pkg::CMD_READ, 2))
    else $error("result without a read beat");

  a_result_index : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kmer_index == $past(in_data.read_index, 2)))
    else $error("result index does not match read beat");

endmodule

bind canonical_kmer_counter_top kcc_checker u_kcc_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import kcc_pkg::*;

  localparam int KW = 2 * KMER_LEN_DEF;
  localparam int CYCLE_LIMIT = 500000;
  // Command three and strand mode three have no names in the package.
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [1:0] MODE_REV_ALT = 2'd3;

  // Tracks the k-mer shift registers and the count table, and holds the counts
  // that pending read beats should return, oldest first.
  class kmer_tally;
    bit [KW-1:0] fwd_kmer;
    bit [KW-1:0] rev_kmer;
    int unsigned loaded;
    bit [1:0] strand;
    bit [COUNT_BITS_DEF-1:0] counts [TABLE_DEPTH];
    out_item_t pending_reads [$];
    bit [TABLE_AW-1:0] touched [$];
    int errors;

    function void set_strand(bit [1:0] m);
      strand = m;
    endfunction

    function bit [CODE_W-1:0] code_of(bit [7:0] ch);
      bit [7:0] up;
      up = ch & 8'hDF;
      if (up == CH_A_UC) return CODE_A;
      if (up == CH_C_UC) return CODE_C;
      if (up == CH_G_UC) return CODE_G;
      if (up == CH_T_UC) return CODE_T;
      return CODE_BAD;
    endfunction

    function void take_command(in_item_t it);
      bit [CODE_W-1:0] code;
      bit [KW-1:0] pick;
      bit [TABLE_AW-1:0] idx;
      bit [COUNT_BITS_DEF-1:0] c;
      out_item_t want;
      case (it.command)
        CMD_ADD: begin
          code = code_of(it.base_char);
          if (code == CODE_BAD) begin
            loaded = 0;
          end else begin
            fwd_kmer = {fwd_kmer[KW-3:0], code[1:0]};
            rev_kmer = {2'd3 - code[1:0], rev_kmer[KW-1:2]};
            if (loaded < KMER_LEN_DEF - 1) begin
              loaded++;
            end else begin
              if (strand == MODE_CANON) begin
                pick = (fwd_kmer < rev_kmer) ? fwd_kmer : rev_kmer;
              end else if (strand == MODE_FWD) begin
                pick = fwd_kmer;
              end else begin
                pick = rev_kmer;
              end
              idx = pick[TABLE_AW-1:0];
              if (counts[idx] != '1) counts[idx]++;
              touched.push_back(idx);
            end
          end
        end
        CMD_END: loaded = 0;
        CMD_READ: begin
          c = counts[it.read_index];
          want.kmer_index = it.read_index;
          want.kmer_count = (c > OUT_COUNT_MAX) ? OUT_COUNT_MAX : OUT_COUNT_W'(c);
          pending_reads.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void check_read(out_item_t got);
      out_item_t want;
      if (pending_reads.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual index %h count %0d",
                 $time, got.kmer_index, got.kmer_count);
        return;
      end
      want = pending_reads.pop_front();
      if (got.kmer_index !== want.kmer_index) begin
        errors++;
        $display("%0t kmer_index mismatch: expected %h, actual %h",
                 $time, want.kmer_index, got.kmer_index);
      end
      if (got.kmer_count !== want.kmer_count) begin
        errors++;
        $display("%0t kmer_count mismatch at %h: expected %0d, actual %0d",
                 $time, want.kmer_index, want.kmer_count, got.kmer_count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MODE_W-1:0] cfg_data = '0;

  kmer_tally tally = new;
  bit no_gap;
  int cycles;

  always #5 clk = ~clk;

  canonical_kmer_counter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tally.set_strand(cfg_data);
      if (start && !busy) tally.take_command(in_data);
      if (out_valid) tally.check_read(out_data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] letter(logic [1:0] code, bit lower);
    logic [7:0] up;
    case ({1'b0, code})
      CODE_A:  up = CH_A_UC;
      CODE_C:  up = CH_C_UC;
      CODE_G:  up = CH_G_UC;
      default: up = CH_T_UC;
    endcase
    return lower ? (up | 8'h20) : up;
  endfunction

  function automatic logic [15:0] counted_index();
    if (tally.touched.size() == 0) return 16'($urandom_range(0, 65535));
    return tally.touched[$urandom_range(0, tally.touched.size() - 1)];
  endfunction

  // A beat that should follow right after the previous one keeps start high.
  task automatic send_beat(logic [1:0] cmd, logic [7:0] ch, logic [15:0] idx);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{command: cmd, base_char: ch, read_index: idx};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain(int settle);
    int n;
    start <= 1'b0;
    @(posedge clk);
    n = 0;
    while (tally.pending_reads.size() > 0 && n < 100) begin
      @(posedge clk);
      n++;
    end
    if (tally.pending_reads.size() > 0) begin
      tally.errors++;
      $display("%0t %0d read results never arrived", $time, tally.pending_reads.size());
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_strand(logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // Mostly clean base runs; some bad characters, ends, reads and dead commands.
  task automatic random_beat(bit two_letter);
    int r;
    logic [1:0] cmd;
    logic [1:0] code;
    logic [7:0] ch;
    logic [15:0] idx;
    r = $urandom_range(0, 99);
    ch = 8'($urandom_range(0, 255));
    idx = 16'($urandom_range(0, 65535));
    if (r < 3) begin
      cmd = CMD_END;
    end else if (r < 5) begin
      cmd = CMD_NONE;
    end else if (r < 20) begin
      cmd = CMD_READ;
      if ($urandom_range(0, 1)) idx = counted_index();
    end else begin
      cmd = CMD_ADD;
      if (r >= 25) begin
        if (two_letter) code = $urandom_range(0, 1) ? CODE_T[1:0] : CODE_A[1:0];
        else code = 2'($urandom_range(0, 3));
        ch = letter(code, 1'($urandom_range(0, 1)));
      end
    end
    send_beat(cmd, ch, idx);
  endtask

  initial begin
    string bases;
    logic [1:0] plan [8];
    int i;
    int p;
    plan = '{MODE_FWD, MODE_REV, MODE_REV_ALT, MODE_CANON,
             MODE_FWD, MODE_REV_ALT, MODE_REV, MODE_CANON};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_strand(MODE_CANON);

    no_gap = 1'b0;
    send_beat(CMD_READ, 8'h00, 16'h0000);
    send_beat(CMD_READ, 8'hFF, 16'hFFFF);
    send_beat(CMD_NONE, 8'hFF, 16'hFFFF);
    bases = "ACGTacgtTg";
    for (i = 0; i < bases.len(); i++) send_beat(CMD_ADD, bases[i], 16'h0000);
    // ACGTACGT is its own reverse complement.
    send_beat(CMD_READ, 8'h00, 16'h1B1B);
    send_beat(CMD_ADD, 8'h4E, 16'hFFFF);
    send_beat(CMD_ADD, 8'h00, 16'h0000);
    send_beat(CMD_ADD, 8'hFF, 16'hFFFF);
    // A partial k-mer shifts without counting.
    send_beat(CMD_ADD, CH_C_UC, 16'h0000);
    send_beat(CMD_ADD, CH_A_LC, 16'h0000);
    send_beat(CMD_END, 8'hFF, 16'hFFFF);
    send_beat(CMD_ADD, CH_G_LC, 16'h0000);
    send_beat(CMD_READ, 8'h00, counted_index());
    send_beat(CMD_READ, 8'h00, counted_index());
    drain(6);

    for (p = 0; p < 8; p++) begin
      write_strand(plan[p]);
      for (i = 0; i < 200; i++) begin
        if (i % 40 == 0) no_gap = ($urandom_range(0, 2) == 0);
        random_beat(p % 3 == 1);
      end
      drain(6);
    end

    drain(8);
    if (tally.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/kcc_pkg.sv
design/kcc_ram.sv
design/kcc_kmer.sv
design/kcc_update.sv
design/canonical_kmer_counter_top.sv
design/kcc_checker.sv
tb/sv/testbench.sv
